>>> src/ihbf_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header builder and filter package
// Shared types and constants for the header builder and the receive filter.
// ----------------------------------------------------------------------------
package ihbf_pkg;

	localparam int HDR_WORDS = 10;
	localparam int IDX_W     = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

	localparam logic [15:0] VER_IHL_TOS = 16'h4500;
	localparam logic [16:0] HDR_BYTES   = 17'd20;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [31:0] ZERO_IP     = 32'h0000_0000;
	localparam logic [7:0]  TTL_RESET   = 8'd64;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 72;

	typedef enum logic {
		OP_SEND = 1'b0,
		OP_RECV = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CLS_ICMP  = 2'd0,
		CLS_UDP   = 2'd1,
		CLS_TCP   = 2'd2,
		CLS_OTHER = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		REG_MY_IP    = 2'd0,
		REG_NET_MASK = 2'd1,
		REG_GATEWAY  = 2'd2,
		REG_TTL      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] my_ip;
		logic [31:0] net_mask;
		logic [31:0] gateway_ip;
		logic [7:0]  time_to_live;
	} cfg_t;

	typedef struct packed {
		op_t         operation;
		logic [31:0] address;
		logic [7:0]  protocol;
		logic [15:0] length;
		logic [3:0]  header_words;
	} item_t;

	typedef struct packed {
		op_t         result_kind;
		logic [15:0] header_word;
		logic [31:0] next_hop_ip;
		logic        accepted;
		cls_t        protocol_class;
		logic [15:0] upper_length;
		logic        length_error;
		logic        last;
	} result_t;

endpackage

>>> src/ipv4_header_builder_and_filter.sv
// ----------------------------------------------------------------------------
// IPv4 header builder and destination filter
// Emits the ten words of an IPv4 header for a send request, or one verdict
// for a received packet.
//
// Input stream s_axis: one word per request. s_axis_tuser selects a send (0)
// or a receive check (1). Output stream m_axis: a send gives ten words, one
// per cycle while m_axis_tready is high, tlast on the tenth; a receive check
// gives one word with tlast. A request is held in an input register while
// its words are produced by the word counter; each result word lands in an
// output register. Receive checks are taken every cycle while m_axis_tready
// is high; a send holds the input register while the counter walks its ten
// header words, and the next request is taken as its last word is loaded.
// Registers are written through wr_en, wr_index and wr_data; the user must
// write them only while the block is idle, which it does not enforce. Reset
// clears the registers (TTL to 64), empties both stages. When m_axis_tready
// is low the output word holds and the input register stops advancing.
// ----------------------------------------------------------------------------
module ipv4_header_builder_and_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [1:0]                            wr_index,
	input  logic [31:0]                           wr_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// address, protocol, length, header_words, zero pad
	input  logic [ihbf_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// operation
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// header_word, next_hop_ip, accepted, protocol_class, upper_length,
	// length_error, zero pad
	output logic [ihbf_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// result_kind
	output logic                                  m_axis_tuser,
	output logic                                  m_axis_tlast
);
	import ihbf_pkg::*;

	cfg_t             cfg_q;
	item_t            item_s1;
	logic             valid_s1;
	logic [IDX_W-1:0] cnt_q;
	result_t          res;
	result_t          res_s2;
	logic             valid_s2;
	logic             load;
	logic             done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.my_ip        <= ZERO_IP;
			cfg_q.net_mask     <= ZERO_IP;
			cfg_q.gateway_ip   <= ZERO_IP;
			cfg_q.time_to_live <= TTL_RESET;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MY_IP:    cfg_q.my_ip        <= wr_data;
				REG_NET_MASK: cfg_q.net_mask     <= wr_data;
				REG_GATEWAY:  cfg_q.gateway_ip   <= wr_data;
				REG_TTL:      cfg_q.time_to_live <= wr_data[7:0];
				default:      cfg_q.my_ip        <= cfg_q.my_ip;
			endcase
		end
	end

	ihbf_calc u_calc (
		.cfg  (cfg_q),
		.item (item_s1),
		.idx  (cnt_q),
		.res  (res)
	);

	assign load          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign done          = load && res.last;
	assign s_axis_tready = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				cnt_q <= '0;
			end else if (load) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation    <= op_t'(s_axis_tuser);
			item_s1.address      <= s_axis_tdata[31:0];
			item_s1.protocol     <= s_axis_tdata[39:32];
			item_s1.length       <= s_axis_tdata[55:40];
			item_s1.header_words <= s_axis_tdata[59:56];
		end
		if (load) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.result_kind;
	assign m_axis_tlast  = res_s2.last;
	assign m_axis_tdata  = {4'd0, res_s2.length_error, res_s2.upper_length,
		res_s2.protocol_class, res_s2.accepted, res_s2.next_hop_ip,
		res_s2.header_word};

	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> cnt_q == '0)
		else $error("word counter advanced with no request held");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_IDX)
		else $error("word counter ran past the last header word");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.operation == OP_RECV |-> cnt_q == '0)
		else $error("receive check reached a nonzero word index");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == OP_SEND && !m_axis_tlast)
		|=> (!m_axis_tvalid || m_axis_tuser == OP_SEND))
		else $error("send header interrupted before its last word");

endmodule

>>> src/ihbf_calc.sv
// ----------------------------------------------------------------------------
// IPv4 header word and receive verdict logic
// Builds one header word of a send, with checksum and next hop, or the
// verdict of a receive check, from the held item and the registers.
// ----------------------------------------------------------------------------
module ihbf_calc (
	input  ihbf_pkg::cfg_t                 cfg,
	input  ihbf_pkg::item_t                item,
	input  logic [ihbf_pkg::IDX_W-1:0]     idx,
	output ihbf_pkg::result_t              res
);
	import ihbf_pkg::*;

	logic [16:0] total;
	logic [15:0] ttl_proto;
	logic [18:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] csum;
	logic [31:0] hop;
	logic [15:0] word;
	logic        acc;
	logic [15:0] hdr_bytes;
	cls_t        cls;
	logic [15:0] ulen;
	logic        rerr;

	always_comb begin
		total     = {1'b0, item.length} + HDR_BYTES;
		ttl_proto = {cfg.time_to_live, item.protocol};
		sum = 19'(VER_IHL_TOS) + 19'(total[15:0]) + 19'(ttl_proto)
			+ 19'(cfg.my_ip[31:16]) + 19'(cfg.my_ip[15:0])
			+ 19'(item.address[31:16]) + 19'(item.address[15:0]);
		fold1 = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		csum  = ~fold2;
		hop   = ((item.address & cfg.net_mask) == (cfg.my_ip & cfg.net_mask))
			? item.address : cfg.gateway_ip;

		case (idx)
			4'd0:    word = VER_IHL_TOS;
			4'd1:    word = total[15:0];
			4'd4:    word = ttl_proto;
			4'd5:    word = csum;
			4'd6:    word = cfg.my_ip[31:16];
			4'd7:    word = cfg.my_ip[15:0];
			4'd8:    word = item.address[31:16];
			4'd9:    word = item.address[15:0];
			default: word = 16'd0;
		endcase

		acc = (cfg.my_ip == ZERO_IP) || (item.address == cfg.my_ip)
			|| (item.address == (cfg.my_ip | ~cfg.net_mask))
			|| (item.address == ALL_ONES);
		hdr_bytes = {10'd0, item.header_words, 2'b00};
		cls  = CLS_OTHER;
		ulen = 16'd0;
		rerr = 1'b0;
		if (acc) begin
			ulen = item.length;
			case (item.protocol)
				PROTO_ICMP: cls = CLS_ICMP;
				PROTO_UDP:  cls = CLS_UDP;
				PROTO_TCP: begin
					cls = CLS_TCP;
					if (hdr_bytes > item.length) begin
						ulen = 16'd0;
						rerr = 1'b1;
					end else begin
						ulen = item.length - hdr_bytes;
					end
				end
				default:    cls = CLS_OTHER;
			endcase
		end

		if (item.operation == OP_SEND) begin
			res.result_kind    = OP_SEND;
			res.header_word    = word;
			res.next_hop_ip    = hop;
			res.accepted       = 1'b0;
			res.protocol_class = CLS_ICMP;
			res.upper_length   = 16'd0;
			res.length_error   = total[16];
			res.last           = (idx == LAST_IDX);
		end else begin
			res.result_kind    = OP_RECV;
			res.header_word    = 16'd0;
			res.next_hop_ip    = ZERO_IP;
			res.accepted       = acc;
			res.protocol_class = cls;
			res.upper_length   = ulen;
			res.length_error   = rerr;
			res.last           = 1'b1;
		end
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// IPv4 header builder and filter testbench
// Drives send requests and receive checks into the stream input under several
// register settings and checks every output word against a built-in predictor
// of the header words, checksum, next hop and receive verdict. Both stream
// sides stall at random in bursts; the closing phase runs without stalls.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ihbf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        wr_en         = 1'b0;
	logic [1:0]  wr_index      = REG_MY_IP;
	logic [31:0] wr_data       = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// address, protocol, length, header_words, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// operation
	logic        s_axis_tuser  = OP_SEND;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// header_word, next_hop_ip, accepted, protocol_class, upper_length,
	// length_error, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// result_kind
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	logic [31:0] host_ip;
	logic [31:0] subnet_mask;
	logic [31:0] router_ip;
	logic [7:0]  hop_limit;

	result_t pending_words[$];
	bit      idle_on        = 1'b0;
	int      stall_left     = 0;
	int      cycle_count    = 0;
	int      error_count    = 0;
	int      words_checked  = 0;
	int      sends_issued   = 0;
	int      checks_issued  = 0;
	int      settings_used  = 0;

	ipv4_header_builder_and_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, pending_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_error(input string what);
		$display("[%0t] ERROR %s", $time, what);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("word %0d: %s is %h, expected %h",
				words_checked, name, got, want));
	endtask

	// expected output words of one request under the current registers
	function automatic void predict_ip_results(input op_t op, input logic [31:0] addr,
		input logic [7:0] proto, input logic [15:0] len, input logic [3:0] ihl);
		logic [15:0] hdr [HDR_WORDS];
		logic [16:0] total;
		logic [31:0] sum;
		logic [31:0] hop;
		logic [15:0] hdr_bytes;
		result_t     r;
		bit          acc;

		r = '0;
		if (op == OP_SEND) begin
			total   = {1'b0, len} + HDR_BYTES;
			hdr[0]  = VER_IHL_TOS;
			hdr[1]  = total[15:0];
			hdr[2]  = '0;
			hdr[3]  = '0;
			hdr[4]  = {hop_limit, proto};
			hdr[5]  = '0;
			hdr[6]  = host_ip[31:16];
			hdr[7]  = host_ip[15:0];
			hdr[8]  = addr[31:16];
			hdr[9]  = addr[15:0];
			sum = '0;
			for (int i = 0; i < HDR_WORDS; i++)
				sum += 32'(hdr[i]);
			while (sum[31:16] != 0)
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
			hdr[5] = ~sum[15:0];
			hop = ((addr & subnet_mask) == (host_ip & subnet_mask)) ? addr : router_ip;
			for (int i = 0; i < HDR_WORDS; i++) begin
				r.result_kind    = OP_SEND;
				r.header_word    = hdr[i];
				r.next_hop_ip    = hop;
				r.accepted       = 1'b0;
				r.protocol_class = CLS_ICMP;
				r.upper_length   = '0;
				r.length_error   = total[16];
				r.last           = (i == HDR_WORDS - 1);
				pending_words.push_back(r);
			end
		end else begin
			acc = host_ip == ZERO_IP || addr == host_ip ||
				addr == (host_ip | ~subnet_mask) || addr == ALL_ONES;
			r.result_kind    = OP_RECV;
			r.accepted       = acc;
			r.protocol_class = CLS_OTHER;
			r.last           = 1'b1;
			if (acc) begin
				r.upper_length = len;
				if (proto == PROTO_ICMP)
					r.protocol_class = CLS_ICMP;
				else if (proto == PROTO_UDP)
					r.protocol_class = CLS_UDP;
				else if (proto == PROTO_TCP) begin
					r.protocol_class = CLS_TCP;
					hdr_bytes = {10'h0, ihl, 2'b00};
					if (hdr_bytes > len) begin
						r.upper_length = '0;
						r.length_error = 1'b1;
					end else begin
						r.upper_length = len - hdr_bytes;
					end
				end
			end
			pending_words.push_back(r);
		end
	endfunction

	task automatic send_request(input op_t op, input logic [31:0] addr,
		input logic [7:0] proto, input logic [15:0] len, input logic [3:0] ihl);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, ihl, len, proto, addr};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		predict_ip_results(op, addr, proto, len, ihl);
		if (op == OP_SEND)
			sends_issued++;
		else
			checks_issued++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_register(input reg_idx_t idx, input logic [31:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_registers(input logic [31:0] ip, input logic [31:0] mask,
		input logic [31:0] gw, input logic [31:0] ttl_word);
		drain();
		put_register(REG_MY_IP, ip);
		put_register(REG_NET_MASK, mask);
		put_register(REG_GATEWAY, gw);
		put_register(REG_TTL, ttl_word);
		wr_en       <= 1'b0;
		host_ip     = ip;
		subnet_mask = mask;
		router_ip   = gw;
		hop_limit   = ttl_word[7:0];
		settings_used++;
	endtask

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 7))
			0: return host_ip;
			1: return host_ip | ~subnet_mask;
			2: return ALL_ONES;
			3: return (host_ip & subnet_mask) | ($urandom & ~subnet_mask);
			4: return ZERO_IP;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_protocol();
		case ($urandom_range(0, 5))
			0: return PROTO_ICMP;
			1: return PROTO_UDP;
			2, 3: return PROTO_TCP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_length(input logic [3:0] ihl);
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'({ihl, 2'b00} + $urandom_range(0, 2) - 1);
			2: return 16'($urandom_range(65500, 65535));
			default: return 16'($urandom_range(0, 1500));
		endcase
	endfunction

	task automatic random_requests(input int count);
		logic [3:0] ihl;
		for (int i = 0; i < count; i++) begin
			ihl = 4'($urandom_range(0, 15));
			send_request(op_t'($urandom_range(0, 1)), pick_address(), pick_protocol(),
				pick_length(ihl), ihl);
		end
	endtask

	task automatic test_reset_values;
		// unconfigured host: TTL 64, every packet accepted
		send_request(OP_SEND, ZERO_IP, 8'h00, 16'h0000, 4'h0);
		send_request(OP_SEND, ALL_ONES, 8'hFF, 16'hFFFF, 4'hF);
		send_request(OP_SEND, 32'h0A00_0002, PROTO_UDP, 16'd65515, 4'h5);
		send_request(OP_SEND, 32'h0A00_0003, PROTO_TCP, 16'd65516, 4'h5);
		send_request(OP_RECV, 32'h1234_5678, PROTO_TCP, 16'd100, 4'h5);
		send_request(OP_RECV, ZERO_IP, 8'h00, 16'hFFFF, 4'hF);
		drain();
	endtask

	task automatic test_directed_filter;
		load_registers(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'h0000_00FF);
		send_request(OP_SEND, 32'hC0A8_0114, PROTO_UDP, 16'd512, 4'h0);
		send_request(OP_SEND, 32'h0808_0808, PROTO_ICMP, 16'd64, 4'h0);
		send_request(OP_RECV, 32'hC0A8_010A, PROTO_ICMP, 16'd84, 4'h5);
		send_request(OP_RECV, 32'hC0A8_01FF, PROTO_UDP, 16'd300, 4'h5);
		send_request(OP_RECV, ALL_ONES, PROTO_UDP, 16'd68, 4'h5);
		send_request(OP_RECV, 32'hC0A8_010B, PROTO_UDP, 16'd68, 4'h5);
		send_request(OP_RECV, 32'hC0A8_010B, PROTO_TCP, 16'd10, 4'hF);
		send_request(OP_RECV, 32'hC0A8_010A, PROTO_TCP, 16'd40, 4'h5);
		send_request(OP_RECV, 32'hC0A8_010A, PROTO_TCP, 16'd59, 4'hF);
		send_request(OP_RECV, 32'hC0A8_010A, PROTO_TCP, 16'd60, 4'hF);
		send_request(OP_RECV, 32'hC0A8_010A, PROTO_TCP, 16'd7, 4'h0);
		send_request(OP_RECV, 32'hC0A8_010A, PROTO_TCP, 16'd3, 4'h1);
		send_request(OP_RECV, 32'hC0A8_010A, 8'd99, 16'hFFFF, 4'h5);
		drain();
	endtask

	task automatic test_register_extremes;
		load_registers(ALL_ONES, ALL_ONES, ZERO_IP, 32'hFFFF_FF00);
		random_requests(20);
		load_registers(32'h0A00_0001, ZERO_IP, ALL_ONES, 32'h5A5A_A501);
		random_requests(20);
	endtask

	task automatic test_random_traffic;
		int prefix;
		logic [31:0] mask;
		for (int phase = 0; phase < 4; phase++) begin
			prefix = $urandom_range(0, 32);
			mask   = (prefix == 0) ? ZERO_IP : ALL_ONES << (32 - prefix);
			load_registers(($urandom_range(0, 4) == 0) ? ZERO_IP : $urandom, mask,
				$urandom, $urandom);
			idle_on = (phase != 3);
			random_requests(45);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.result_kind    = op_t'(m_axis_tuser);
			got.header_word    = m_axis_tdata[15:0];
			got.next_hop_ip    = m_axis_tdata[47:16];
			got.accepted       = m_axis_tdata[48];
			got.protocol_class = cls_t'(m_axis_tdata[50:49]);
			got.upper_length   = m_axis_tdata[66:51];
			got.length_error   = m_axis_tdata[67];
			got.last           = m_axis_tlast;
			if (pending_words.size() == 0) begin
				report_error($sformatf("unexpected word, tdata %h tuser %b tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end else begin
				want = pending_words.pop_front();
				compare_field("result_kind", 32'(got.result_kind),
					32'(want.result_kind));
				compare_field("header_word", 32'(got.header_word),
					32'(want.header_word));
				compare_field("next_hop_ip", got.next_hop_ip, want.next_hop_ip);
				compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
				compare_field("protocol_class", 32'(got.protocol_class),
					32'(want.protocol_class));
				compare_field("upper_length", 32'(got.upper_length),
					32'(want.upper_length));
				compare_field("length_error", 32'(got.length_error),
					32'(want.length_error));
				compare_field("last", 32'(got.last), 32'(want.last));
			end
			words_checked++;
		end
	end

	// output-side stalls
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left    <= 0;
			m_axis_tready <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left    <= $urandom_range(1, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		host_ip     = ZERO_IP;
		subnet_mask = ZERO_IP;
		router_ip   = ZERO_IP;
		hop_limit   = TTL_RESET;
		repeat (10) @(posedge clk);
		arst_n  <= 1'b1;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);

		test_reset_values();
		test_directed_filter();
		test_register_extremes();
		test_random_traffic();

		drain();
		repeat (20) @(posedge clk);
		if (pending_words.size() != 0)
			report_error($sformatf("%0d words never arrived", pending_words.size()));

		$display("sent %0d header requests and %0d receive checks over %0d register settings",
			sends_issued, checks_issued, settings_used);
		$display("checked %0d output words, %0d errors", words_checked, error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
